// ===== rtl/wtc_pkg.sv =====
package wtc_pkg;

    localparam int TEX_SIZE      = 64;
    localparam int SCREEN_HEIGHT = 1024;

    localparam int QUO_W   = $clog2(TEX_SIZE * 65536 + 1);
    localparam int OFF_W   = 18;
    localparam int STEP_W  = 23;
    localparam int START_W = 27;
    localparam int PROD_W  = OFF_W + STEP_W + 1;

    localparam logic [31:0] STEP_MAX = 32'd8388607;
    localparam logic signed [PROD_W-1:0] POS_MAX = PROD_W'(67108863);
    localparam logic signed [PROD_W-1:0] POS_MIN = -PROD_W'(67108864);

    typedef enum logic [1:0] {
        TEX_NORTH = 2'd0,
        TEX_SOUTH = 2'd1,
        TEX_WEST  = 2'd2,
        TEX_EAST  = 2'd3
    } t_tex_sel;

endpackage

// ===== rtl/wall_texture_coordinates_core.sv =====
// Pipeline from an accepted item to its result: one input stage,
// one stage per quotient bit of the 23-bit row step divider, a multiply
// stage and the output register.
// Throughput: one item per cycle; a stall at the output freezes all stages.
// Reset (i_rst_n low, synchronous) clears every valid bit; data is not reset.
module wall_texture_coordinates_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_hit_side,
    input  logic                           i_step_x_negative,
    input  logic                           i_step_y_negative,
    input  logic signed [15:0]             i_ray_dir_x,
    input  logic signed [15:0]             i_ray_dir_y,
    input  logic [23:0]                    i_player_x,
    input  logic [23:0]                    i_player_y,
    input  logic [23:0]                    i_wall_distance,
    input  logic [15:0]                    i_line_height,
    input  logic [9:0]                     i_first_row,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_texture_select,
    output logic [5:0]                     o_texture_column,
    output logic [wtc_pkg::STEP_W-1:0]     o_row_step,
    output logic signed [wtc_pkg::START_W-1:0] o_start_position
);
    import wtc_pkg::*;

    localparam logic [QUO_W-1:0] DIVIDEND = QUO_W'(TEX_SIZE * 65536);

    logic en;

    // input stage
    logic                    r_vld_a;
    logic [29:0]             r_prod_a;
    logic [15:0]             r_pos_a;
    logic                    r_mirror_a;
    t_tex_sel                r_sel_a;
    logic [15:0]             r_lh_a;
    logic signed [OFF_W-1:0] r_off_a;

    logic signed [40:0]      n_prod_a;
    logic [15:0]             n_lh_a;
    logic signed [OFF_W-1:0] n_off_a;

    // divider stages
    logic                    r_vld_d  [QUO_W];
    logic [15:0]             r_rem_d  [QUO_W];
    logic [QUO_W-1:0]        r_quo_d  [QUO_W];
    logic [15:0]             r_den_d  [QUO_W];
    t_tex_sel                r_sel_d  [QUO_W];
    logic [5:0]              r_col_d  [QUO_W];
    logic signed [OFF_W-1:0] r_off_d  [QUO_W];

    logic [29:0]             hit_frac;
    logic [41:0]             col_scaled;
    logic [31:0]             col_full;
    logic [5:0]              n_col;

    // multiply stage
    logic                    r_vld_m;
    logic signed [PROD_W-1:0] r_start_m;
    logic [STEP_W-1:0]       r_step_m;
    t_tex_sel                r_sel_m;
    logic [5:0]              r_col_m;

    logic [31:0]             quo_ext;
    logic [STEP_W-1:0]       n_step_m;

    // output register
    logic                    r_vld_o;
    t_tex_sel                r_sel_o;
    logic [5:0]              r_col_o;
    logic [STEP_W-1:0]       r_step_o;
    logic signed [START_W-1:0] r_start_o;
    logic signed [START_W-1:0] n_start_o;

    assign en      = !r_vld_o || i_ready;
    assign o_ready = en;

    always_comb begin
        if (i_hit_side == 1'b0) begin
            n_prod_a = $signed({1'b0, i_wall_distance}) * i_ray_dir_y;
        end else begin
            n_prod_a = $signed({1'b0, i_wall_distance}) * i_ray_dir_x;
        end
        n_lh_a  = (i_line_height == 16'd0) ? 16'd1 : i_line_height;
        n_off_a = $signed({8'd0, i_first_row}) - OFF_W'(SCREEN_HEIGHT / 2)
                  + $signed({3'd0, n_lh_a[15:1]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (en) begin
            r_vld_a <= i_valid;
        end
        if (en) begin
            r_prod_a   <= n_prod_a[29:0];
            r_pos_a    <= i_hit_side ? i_player_x[15:0] : i_player_y[15:0];
            r_mirror_a <= (!i_hit_side && (i_ray_dir_x > 16'sd0))
                          || (i_hit_side && (i_ray_dir_y < 16'sd0));
            if (i_hit_side == 1'b0) begin
                r_sel_a <= i_step_x_negative ? TEX_WEST : TEX_EAST;
            end else begin
                r_sel_a <= i_step_y_negative ? TEX_NORTH : TEX_SOUTH;
            end
            r_lh_a  <= n_lh_a;
            r_off_a <= n_off_a;
        end
    end

    always_comb begin
        hit_frac   = {r_pos_a, 14'd0} + r_prod_a;
        col_scaled = {12'd0, hit_frac} * 42'(TEX_SIZE);
        col_full   = 32'(col_scaled >> 30);
        if (r_mirror_a) begin
            col_full = 32'(TEX_SIZE - 1) - col_full;
        end
        n_col = col_full[5:0];
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        logic             vld_in;
        logic [15:0]      rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [15:0]      den_in;
        t_tex_sel         sel_in;
        logic [5:0]       col_in;
        logic signed [OFF_W-1:0] off_in;
        logic [16:0]      trial;
        logic [16:0]      diff;
        logic             qbit;

        if (j == 0) begin : g_first
            assign vld_in = r_vld_a;
            assign rem_in = 16'd0;
            assign quo_in = '0;
            assign den_in = r_lh_a;
            assign sel_in = r_sel_a;
            assign col_in = n_col;
            assign off_in = r_off_a;
        end else begin : g_next
            assign vld_in = r_vld_d[j-1];
            assign rem_in = r_rem_d[j-1];
            assign quo_in = r_quo_d[j-1];
            assign den_in = r_den_d[j-1];
            assign sel_in = r_sel_d[j-1];
            assign col_in = r_col_d[j-1];
            assign off_in = r_off_d[j-1];
        end

        always_comb begin
            trial = {rem_in, DIVIDEND[QUO_W-1-j]};
            diff  = trial - {1'b0, den_in};
            qbit  = (trial >= {1'b0, den_in});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_d[j] <= 1'b0;
            end else if (en) begin
                r_vld_d[j] <= vld_in;
            end
            if (en) begin
                r_rem_d[j] <= qbit ? diff[15:0] : trial[15:0];
                r_quo_d[j] <= {quo_in[QUO_W-2:0], qbit};
                r_den_d[j] <= den_in;
                r_sel_d[j] <= sel_in;
                r_col_d[j] <= col_in;
                r_off_d[j] <= off_in;
            end
        end
    end

    always_comb begin
        quo_ext  = 32'(r_quo_d[QUO_W-1]);
        n_step_m = (quo_ext > STEP_MAX) ? STEP_MAX[STEP_W-1:0] : quo_ext[STEP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m <= 1'b0;
        end else if (en) begin
            r_vld_m <= r_vld_d[QUO_W-1];
        end
        if (en) begin
            r_start_m <= r_off_d[QUO_W-1] * $signed({1'b0, n_step_m});
            r_step_m  <= n_step_m;
            r_sel_m   <= r_sel_d[QUO_W-1];
            r_col_m   <= r_col_d[QUO_W-1];
        end
    end

    always_comb begin
        if (r_start_m > POS_MAX) begin
            n_start_o = POS_MAX[START_W-1:0];
        end else if (r_start_m < POS_MIN) begin
            n_start_o = POS_MIN[START_W-1:0];
        end else begin
            n_start_o = r_start_m[START_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (en) begin
            r_vld_o <= r_vld_m;
        end
        if (en) begin
            r_sel_o   <= r_sel_m;
            r_col_o   <= r_col_m;
            r_step_o  <= r_step_m;
            r_start_o <= n_start_o;
        end
    end

    assign o_valid          = r_vld_o;
    assign o_texture_select = r_sel_o;
    assign o_texture_column = r_col_o;
    assign o_row_step       = r_step_o;
    assign o_start_position = r_start_o;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import wtc_pkg::*;

    localparam int    CYCLE_LIMIT = 400000;
    localparam int    REPORT_CAP  = 200;
    localparam int    RANDOM_ITEMS = 2000;
    localparam int    SEGMENTS    = 8;
    localparam int    TAIL_CYCLES = 40;
    localparam longint STEP_CAP   = 64'sd8388607;
    localparam longint START_HI   = 64'sd67108863;
    localparam longint START_LO   = -64'sd67108864;

    localparam logic [1:0] PH_FREE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;
    localparam logic [1:0] PH_BOTH = 2'd3;

    typedef struct packed {
        logic        hit_side;
        logic        step_x_negative;
        logic        step_y_negative;
        logic [15:0] ray_dir_x;
        logic [15:0] ray_dir_y;
        logic [23:0] player_x;
        logic [23:0] player_y;
        logic [23:0] wall_distance;
        logic [15:0] wall_rows;
        logic [9:0]  first_row;
        logic [1:0]  phase;
        logic        drain;
    } hit_column_t;

    typedef struct packed {
        t_tex_sel    tex;
        logic [5:0]  column;
        logic [22:0] row_step;
        logic [26:0] start_position;
    } wall_texel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic hit_side = 1'b0;
    logic step_x_negative = 1'b0;
    logic step_y_negative = 1'b0;
    logic signed [15:0] ray_dir_x = '0;
    logic signed [15:0] ray_dir_y = '0;
    logic [23:0] player_x = '0;
    logic [23:0] player_y = '0;
    logic [23:0] wall_distance = '0;
    logic [15:0] wall_rows = 16'd1;
    logic [9:0]  first_row = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  texture_select;
    logic [5:0]  texture_column;
    logic [STEP_W-1:0] row_step;
    logic signed [START_W-1:0] start_position;

    hit_column_t columns_to_send[$];
    wall_texel_t texels_due[$];
    hit_column_t col_on_bus;
    logic [1:0]  recv_phase = PH_FREE;
    int          n_issued = 0;
    int          n_resolved = 0;
    int          n_errors = 0;
    int          n_reports = 0;
    int          cycle_count = 0;

    wall_texture_coordinates_core DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (in_valid),
        .o_ready           (in_ready),
        .i_hit_side        (hit_side),
        .i_step_x_negative (step_x_negative),
        .i_step_y_negative (step_y_negative),
        .i_ray_dir_x       (ray_dir_x),
        .i_ray_dir_y       (ray_dir_y),
        .i_player_x        (player_x),
        .i_player_y        (player_y),
        .i_wall_distance   (wall_distance),
        .i_line_height     (wall_rows),
        .i_first_row       (first_row),
        .o_valid           (out_valid),
        .i_ready           (out_ready),
        .o_texture_select  (texture_select),
        .o_texture_column  (texture_column),
        .o_row_step        (row_step),
        .o_start_position  (start_position)
    );

    always #1 clk = ~clk;

    function automatic wall_texel_t predict_texel(input hit_column_t c);
        wall_texel_t r;
        longint base;
        longint dir;
        longint hit;
        longint frac;
        longint col;
        longint lh;
        longint quo;
        longint ofs;
        longint prod;
        if (!c.hit_side) begin
            base  = longint'(c.player_y);
            dir   = longint'($signed(c.ray_dir_y));
            r.tex = c.step_x_negative ? TEX_WEST : TEX_EAST;
        end else begin
            base  = longint'(c.player_x);
            dir   = longint'($signed(c.ray_dir_x));
            r.tex = c.step_y_negative ? TEX_NORTH : TEX_SOUTH;
        end
        hit  = base * 16384 + longint'(c.wall_distance) * dir;
        frac = hit & 64'h3FFF_FFFF;
        col  = (frac * TEX_SIZE) >>> 30;
        if ((!c.hit_side && $signed(c.ray_dir_x) > 0) ||
            (c.hit_side && $signed(c.ray_dir_y) < 0)) begin
            col = TEX_SIZE - 1 - col;
        end
        lh  = (c.wall_rows == 16'd0) ? 64'sd1 : longint'(c.wall_rows);
        quo = (longint'(TEX_SIZE) * 65536) / lh;
        if (quo > STEP_CAP) begin
            quo = STEP_CAP;
        end
        ofs  = longint'(c.first_row) - SCREEN_HEIGHT / 2 + lh / 2;
        prod = ofs * quo;
        if (prod > START_HI) begin
            prod = START_HI;
        end else if (prod < START_LO) begin
            prod = START_LO;
        end
        r.column         = col[5:0];
        r.row_step       = quo[22:0];
        r.start_position = prod[26:0];
        return r;
    endfunction

    function automatic hit_column_t make_column(input logic side, input logic sxn,
                                                input logic syn, input logic [15:0] dx,
                                                input logic [15:0] dy, input logic [23:0] px,
                                                input logic [23:0] py, input logic [23:0] wdist,
                                                input logic [15:0] lh, input logic [9:0] row);
        hit_column_t c;
        c.hit_side        = side;
        c.step_x_negative = sxn;
        c.step_y_negative = syn;
        c.ray_dir_x       = dx;
        c.ray_dir_y       = dy;
        c.player_x        = px;
        c.player_y        = py;
        c.wall_distance   = wdist;
        c.wall_rows       = lh;
        c.first_row       = row;
        c.phase           = PH_FREE;
        c.drain           = 1'b0;
        return c;
    endfunction

    function automatic logic [15:0] random_dir();
        logic [15:0] d;
        case ($urandom_range(9))
            0: d = 16'h8000;
            1: d = 16'h7FFF;
            2: d = ($urandom_range(1) != 0) ? 16'h0001 : 16'hFFFF;
            3: d = 16'h0000;
            default: d = 16'($urandom);
        endcase
        return d;
    endfunction

    function automatic hit_column_t random_column(input logic [1:0] phase);
        hit_column_t c;
        c.hit_side        = 1'($urandom_range(1));
        c.step_x_negative = 1'($urandom_range(1));
        c.step_y_negative = 1'($urandom_range(1));
        c.ray_dir_x       = random_dir();
        c.ray_dir_y       = random_dir();
        c.player_x        = 24'($urandom);
        c.player_y        = 24'($urandom);
        c.wall_distance   = ($urandom_range(1) != 0) ? 24'($urandom_range(0, 24'h0F_FFFF))
                                                     : 24'($urandom);
        case ($urandom_range(9))
            0: c.wall_rows = 16'd0;
            1: c.wall_rows = ($urandom_range(1) != 0) ? 16'd1 : 16'hFFFF;
            2: c.wall_rows = 16'($urandom_range(1, 16));
            3, 4, 5, 6: c.wall_rows = 16'($urandom_range(1, 1024));
            default: c.wall_rows = 16'($urandom);
        endcase
        c.first_row = 10'($urandom);
        c.phase     = phase;
        c.drain     = 1'b0;
        return c;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            n_errors++;
            if (n_reports < REPORT_CAP) begin
                n_reports++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                texels_due.push_back(predict_texel(col_on_bus));
                n_issued++;
            end
            if (!in_valid || in_ready) begin
                if (columns_to_send.size() != 0 &&
                    !(columns_to_send[0].drain && n_issued != n_resolved) &&
                    $urandom_range(99) >= ((columns_to_send[0].phase == PH_SEND) ? 54 :
                                           (columns_to_send[0].phase == PH_BOTH) ? 10 : 0)) begin
                    col_on_bus = columns_to_send.pop_front();
                    hit_side        <= col_on_bus.hit_side;
                    step_x_negative <= col_on_bus.step_x_negative;
                    step_y_negative <= col_on_bus.step_y_negative;
                    ray_dir_x       <= col_on_bus.ray_dir_x;
                    ray_dir_y       <= col_on_bus.ray_dir_y;
                    player_x        <= col_on_bus.player_x;
                    player_y        <= col_on_bus.player_y;
                    wall_distance   <= col_on_bus.wall_distance;
                    wall_rows       <= col_on_bus.wall_rows;
                    first_row       <= col_on_bus.first_row;
                    recv_phase      <= col_on_bus.phase;
                    in_valid        <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        wall_texel_t want;
        if (out_valid && out_ready) begin
            if (texels_due.size() == 0) begin
                n_errors++;
                if (n_reports < REPORT_CAP) begin
                    n_reports++;
                    $display("%0t: unexpected item, expected none, actual tex %0d col %0d",
                             $time, texture_select, texture_column);
                end
            end else begin
                want = texels_due.pop_front();
                check_field("texture_select", longint'(want.tex), longint'(texture_select));
                check_field("texture_column", longint'(want.column), longint'(texture_column));
                check_field("row_step", longint'(want.row_step), longint'(row_step));
                check_field("start_position", longint'($signed(want.start_position)),
                            longint'(start_position));
            end
            n_resolved <= n_resolved + 1;
        end
        out_ready <= $urandom_range(99) >= ((recv_phase == PH_RECV) ? 54 :
                                            (recv_phase == PH_BOTH) ? 10 : 0);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        hit_column_t c;
        logic [1:0]  phase;
        int          seg;
        int          k;
        columns_to_send.push_back(make_column(1'b0, 1'b1, 1'b0, 16'h8000, 16'h7FFF, 24'h0,
                                              24'h0, 24'h0, 16'd0, 10'd0));
        columns_to_send.push_back(make_column(1'b0, 1'b0, 1'b1, 16'h7FFF, 16'h8000, 24'hFFFFFF,
                                              24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 10'd1023));
        columns_to_send.push_back(make_column(1'b1, 1'b1, 1'b1, 16'h8000, 16'hFFFF, 24'hFFFFFF,
                                              24'h0, 24'hFFFFFF, 16'd1, 10'd1023));
        columns_to_send.push_back(make_column(1'b1, 1'b0, 1'b0, 16'h7FFF, 16'h0001, 24'h0,
                                              24'hFFFFFF, 24'hFFFFFF, 16'd1, 10'd0));
        columns_to_send.push_back(make_column(1'b0, 1'b1, 1'b1, 16'h0000, 16'h0001, 24'h123456,
                                              24'h008000, 24'h010000, 16'd2, 10'd511));
        columns_to_send.push_back(make_column(1'b0, 1'b0, 1'b0, 16'h0001, 16'h0001, 24'h0,
                                              24'h008000, 24'h010000, 16'd3, 10'd512));
        columns_to_send.push_back(make_column(1'b1, 1'b1, 1'b0, 16'h4000, 16'h0000, 24'h00C000,
                                              24'h0, 24'h020000, 16'd64, 10'd480));
        columns_to_send.push_back(make_column(1'b1, 1'b0, 1'b1, 16'hC000, 16'hFFFF, 24'h00C000,
                                              24'h0, 24'h020000, 16'd65, 10'd480));
        columns_to_send.push_back(make_column(1'b0, 1'b1, 1'b0, 16'h0005, 16'h0000, 24'h0,
                                              24'h020000, 24'h0, 16'd32768, 10'd0));
        columns_to_send.push_back(make_column(1'b0, 1'b0, 1'b1, 16'hFFFB, 16'h0000, 24'h0,
                                              24'h00FFFF, 24'h0, 16'd65534, 10'd1));
        columns_to_send.push_back(make_column(1'b0, 1'b1, 1'b1, 16'h0001, 16'h0000, 24'h0,
                                              24'h020000, 24'h0, 16'd1024, 10'd0));
        columns_to_send.push_back(make_column(1'b0, 1'b0, 1'b0, 16'h8000, 16'hFFFF, 24'h0,
                                              24'h0, 24'h010000, 16'd0, 10'd1023));
        columns_to_send.push_back(make_column(1'b1, 1'b1, 1'b1, 16'h8000, 16'h8000, 24'h0,
                                              24'hFFFFFF, 24'hFFFFFF, 16'd200, 10'd412));
        columns_to_send.push_back(make_column(1'b1, 1'b0, 1'b0, 16'h7FFF, 16'h7FFF, 24'hFFFFFF,
                                              24'h0, 24'hFFFFFF, 16'd1023, 10'd1));
        columns_to_send.push_back(make_column(1'b0, 1'b1, 1'b0, 16'h7FFF, 16'h8000, 24'hFFFFFF,
                                              24'h000001, 24'h000001, 16'd16, 10'd600));
        columns_to_send.push_back(make_column(1'b1, 1'b0, 1'b1, 16'h0001, 16'h0001, 24'hAAAAAA,
                                              24'h555555, 24'h5A5A5A, 16'hAAAA, 10'h2AA));
        columns_to_send.push_back(make_column(1'b0, 1'b1, 1'b0, 16'h5555, 16'hAAAA, 24'h555555,
                                              24'hAAAAAA, 24'hA5A5A5, 16'h5555, 10'h155));
        columns_to_send.push_back(make_column(1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 24'h7FFFFF,
                                              24'h0, 24'h0, 16'd4096, 10'd1023));
        for (seg = 0; seg < SEGMENTS; seg++) begin
            phase = 2'(seg % 4);
            for (k = 0; k < RANDOM_ITEMS / SEGMENTS; k++) begin
                c = random_column(phase);
                c.drain = (k == 0);
                columns_to_send.push_back(c);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (columns_to_send.size() != 0 || in_valid) @(posedge clk);
        while (n_resolved != n_issued) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0 && texels_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
